@@ hdl/etd_pkg.sv @@
// Shared constants, codes and channel types for the event time decoder.
`timescale 1ns / 1ps
`default_nettype none

package etd_pkg;

  // Core sizes
  localparam int STAMP_BITS = 8;
  localparam int MAX_PACK   = 3;
  localparam int TIME_BITS  = 64;

  // Stamp extension: the stamp (halved) covers the low STAMP_K bits of time
  localparam int STAMP_K   = STAMP_BITS - 1;
  localparam int STAMP_USE = (STAMP_BITS < 8) ? STAMP_BITS : 8;
  localparam int HI_BITS   = TIME_BITS - STAMP_K;

  // Message codes
  typedef enum logic [3:0] {
    OP_JTAG     = 4'd0,
    OP_OMNIBUS  = 4'd1,
    OP_LOOPBACK = 4'd2,
    OP_TIME_SET = 4'd3,
    OP_TIME_ADD = 4'd4,
    OP_SPIKE    = 4'd5,
    OP_SAMPLE   = 4'd6,
    OP_NOTE     = 4'd7,
    OP_TIMEOUT  = 4'd8
  } op_e;

  // Result codes
  typedef enum logic [2:0] {
    KIND_JTAG     = 3'd0,
    KIND_OMNIBUS  = 3'd1,
    KIND_LOOPBACK = 3'd2,
    KIND_SPIKE    = 3'd3,
    KIND_SAMPLE   = 3'd4,
    KIND_NOTE     = 3'd5
  } kind_e;

  // Input request
  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] payload;
    logic        loopback_halt;
    logic [1:0]  event_count;
    logic [15:0] event_value_0;
    logic [15:0] event_value_1;
    logic [15:0] event_value_2;
    logic [7:0]  event_stamp_0;
    logic [7:0]  event_stamp_1;
    logic [7:0]  event_stamp_2;
  } etd_in_t;

  // Result request
  typedef struct packed {
    logic [2:0]  result_kind;
    logic [63:0] value;
    logic [63:0] chip_time;
    logic [63:0] fpga_time;
    logic [31:0] pack_count;
    logic        last;
  } etd_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       emit;
    logic [1:0] evt_idx;
    logic       last;
  } etd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] n_results;
  } etd_sts_t;

endpackage

`default_nettype wire

@@ hdl/etd_datapath.sv @@
// Datapath: running time, pack tallies, held request and result register.
`timescale 1ns / 1ps
`default_nettype none

module etd_datapath import etd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire etd_in_t  in_data_i,
  input  wire etd_cmd_t cmd_i,
  output etd_sts_t      sts_o,
  output etd_out_t      out_data_o
);

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [HI_BITS-1:0]   hi_m1_q, hi_m1_d;
  logic [31:0]          spike_tally_q  [MAX_PACK];
  logic [31:0]          sample_tally_q [MAX_PACK];
  logic [31:0]          pack_cnt_q, pack_cnt_d;
  etd_in_t              item_q;
  etd_out_t             out_q, out_d;

  logic                 in_spike, in_sample, in_pack_ok;
  logic [TIME_BITS-1:0] in_payload_t;

  logic                 item_pack;
  logic [15:0]          ev_value;
  logic [7:0]           ev_stamp;
  logic [STAMP_USE-1:0] stamp_low;
  logic [STAMP_K-1:0]   stamp_k;
  logic [TIME_BITS-1:0] chip_t;

  // Decode incoming request
  assign in_spike     = (in_data_i.operation == OP_SPIKE);
  assign in_sample    = (in_data_i.operation == OP_SAMPLE);
  assign in_pack_ok   = (in_spike || in_sample) && (in_data_i.event_count != 2'd0) &&
                        (32'(in_data_i.event_count) <= MAX_PACK);
  assign in_payload_t = in_data_i.payload[TIME_BITS-1:0];

  // Count results the incoming request causes
  always_comb begin
    unique case (in_data_i.operation) inside
      OP_JTAG, OP_OMNIBUS, OP_NOTE: sts_o.n_results = 2'd1;
      OP_LOOPBACK:                  sts_o.n_results = in_data_i.loopback_halt ? 2'd0 : 2'd1;
      OP_SPIKE, OP_SAMPLE:          sts_o.n_results = in_pack_ok ? in_data_i.event_count : 2'd0;
      default:                      sts_o.n_results = 2'd0;
    endcase
  end

  // Advance, replace or shift the running time; carry-in folds in the tick
  always_comb begin
    unique case (in_data_i.operation) inside
      OP_TIME_SET: time_d = in_payload_t;
      OP_TIME_ADD: time_d = time_q + in_payload_t + TIME_BITS'(1);
      default:     time_d = time_q + TIME_BITS'(1);
    endcase
  end

  // Upper time bits of the advanced time, minus one period
  assign hi_m1_d = (&time_q[STAMP_K-1:0]) ? time_q[TIME_BITS-1:STAMP_K]
                                          : time_q[TIME_BITS-1:STAMP_K] - HI_BITS'(1);

  // Select the bumped tally for this pack size
  always_comb begin
    pack_cnt_d = '0;
    for (int j = 0; j < MAX_PACK; j++) begin
      if (in_data_i.event_count == 2'(j + 1)) begin
        pack_cnt_d = in_spike ? spike_tally_q[j] + 32'd1 : sample_tally_q[j] + 32'd1;
      end
    end
  end

  // Hold time and tallies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      for (int j = 0; j < MAX_PACK; j++) begin
        spike_tally_q[j]  <= '0;
        sample_tally_q[j] <= '0;
      end
    end else if (cmd_i.accept) begin
      time_q <= time_d;
      for (int j = 0; j < MAX_PACK; j++) begin
        if (in_pack_ok && in_data_i.event_count == 2'(j + 1)) begin
          if (in_spike) begin
            spike_tally_q[j] <= spike_tally_q[j] + 32'd1;
          end else begin
            sample_tally_q[j] <= sample_tally_q[j] + 32'd1;
          end
        end
      end
    end
  end

  // Pick the current event of the held pack
  always_comb begin
    case (cmd_i.evt_idx)
      2'd0:    begin ev_value = item_q.event_value_0; ev_stamp = item_q.event_stamp_0; end
      2'd1:    begin ev_value = item_q.event_value_1; ev_stamp = item_q.event_stamp_1; end
      2'd2:    begin ev_value = item_q.event_value_2; ev_stamp = item_q.event_stamp_2; end
      default: begin ev_value = '0;                   ev_stamp = '0;                   end
    endcase
  end

  // Extend the short stamp; step back one period if it lies ahead
  assign stamp_low = ev_stamp[STAMP_USE-1:0];
  assign stamp_k   = STAMP_K'(stamp_low >> 1);
  assign chip_t    = (stamp_k > time_q[STAMP_K-1:0]) ? {hi_m1_q, stamp_k}
                                                     : {time_q[TIME_BITS-1:STAMP_K], stamp_k};
  assign item_pack = (item_q.operation == OP_SPIKE) || (item_q.operation == OP_SAMPLE);

  // Build the next result
  always_comb begin
    out_d.value       = item_q.payload;
    out_d.chip_time   = '0;
    out_d.fpga_time   = 64'(time_q);
    out_d.pack_count  = '0;
    out_d.last        = cmd_i.last;
    unique case (item_q.operation) inside
      OP_JTAG:     out_d.result_kind = KIND_JTAG;
      OP_OMNIBUS:  out_d.result_kind = KIND_OMNIBUS;
      OP_LOOPBACK: out_d.result_kind = KIND_LOOPBACK;
      OP_SPIKE:    out_d.result_kind = KIND_SPIKE;
      OP_SAMPLE:   out_d.result_kind = KIND_SAMPLE;
      default:     out_d.result_kind = KIND_NOTE;
    endcase
    if (item_pack) begin
      out_d.value      = 64'(ev_value);
      out_d.chip_time  = 64'(chip_t);
      out_d.pack_count = pack_cnt_q;
    end
  end

  // Hold request, pack context and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q     <= in_data_i;
      hi_m1_q    <= hi_m1_d;
      pack_cnt_q <= pack_cnt_d;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ hdl/etd_ctrl.sv @@
// Controller: accepts requests and sequences one result per cycle out while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module etd_ctrl import etd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire etd_sts_t sts_i,
  output etd_cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] n_q, n_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  logic       emit_ok, is_last, accept;

  // Load the result register when it is free or being drained
  assign emit_ok    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign is_last    = (idx_q == n_q - 2'd1);
  assign in_ready_o = (state_q == ST_IDLE) || (emit_ok && is_last);
  assign accept     = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit_ok) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + 2'd1;
      if (is_last) begin
        state_d = ST_IDLE;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && sts_i.n_results != 2'd0) begin
      state_d = ST_EMIT;
      n_d     = sts_i.n_results;
      idx_d   = 2'd0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= 2'd0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.accept  = accept;
  assign cmd_o.emit    = emit_ok;
  assign cmd_o.evt_idx = idx_q;
  assign cmd_o.last    = is_last;

  // Event index stays inside the held pack
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> idx_q < n_q)
    else $error("event index past result count");

  // A loaded result is presented next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_ok |=> out_valid_o)
    else $error("emitted result not presented");

  // More results of the same request keep the sequencer busy
  a_emit_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_ok && !is_last |=> state_q == ST_EMIT && !in_ready_o || emit_ok)
    else $error("sequencer left a request unfinished");

  // No request is taken while a pack is mid-sequence
  a_no_accept_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && !is_last |-> !in_ready_o)
    else $error("request accepted during emission");

endmodule

`default_nettype wire

@@ hdl/event_time_decoder_top.sv @@
// Top level of the event time decoder: controller plus datapath.
//
// Each accepted request first advances the running time by one; time-set
// and time-delta requests then replace or shift it and give no result.
// Responses and link notifications give one result tagged with the time,
// a loopback halt or timeout gives none, and a spike or sample pack gives
// one result per event with its short stamp extended to full time. The
// next request is taken in the cycle that emits the last result, and a
// request with no result leaves the sequencer idle; the result register
// emits one result per cycle while the output is not stalled.
// Backpressure on the output stalls the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module event_time_decoder_top import etd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire etd_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output etd_out_t     out_data_o
);

  etd_cmd_t cmd;
  etd_sts_t sts;

  etd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  etd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
